### src/bme_pkg.sv
package bme_pkg;

    localparam int MODULUS_WIDTH_DEFAULT  = 32;
    localparam int EXPONENT_WIDTH_DEFAULT = 32;

    localparam int CFG_WIDTH    = 32;
    localparam int ADDR_WIDTH   = 3;
    localparam int KEY_WIDTH    = 8;
    localparam int CIPHER_WIDTH = 32;
    // key_value plus the ASCII offset needs one bit more than the key
    localparam int BASE_WIDTH   = 9;

    localparam logic [BASE_WIDTH-1:0] ASCII_OFFSET = 9'd48;
    localparam logic [KEY_WIDTH-1:0]  REJECT_A     = 8'h0A;
    localparam logic [KEY_WIDTH-1:0]  REJECT_B     = 8'h0B;
    localparam logic [KEY_WIDTH-1:0]  REJECT_F     = 8'h0F;

    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET  = 32'd1;
    localparam logic [CFG_WIDTH-1:0] EXPONENT_RESET = 32'd65537;

    typedef enum logic {
        REG_MODULUS  = 1'b0,
        REG_EXPONENT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] modulus;
        logic [CFG_WIDTH-1:0] exponent;
    } cfg_t;

endpackage

### src/bme_regs.sv
module bme_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bme_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [bme_pkg::CFG_WIDTH-1:0]  pwdata,
    output logic [bme_pkg::CFG_WIDTH-1:0]  prdata,
    output logic                           pready,
    output bme_pkg::cfg_t                  cfg
);
    import bme_pkg::*;

    logic [CFG_WIDTH-1:0] modulus_reg;
    logic [CFG_WIDTH-1:0] exponent_reg;
    logic [CFG_WIDTH-1:0] modulus_next;
    logic [CFG_WIDTH-1:0] exponent_next;
    reg_index_t           index;
    logic                 wr_en;

    // word address: byte offset bits are ignored
    assign index  = reg_index_t'(paddr[ADDR_WIDTH-1]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_MODULUS:  modulus_next  = pwdata;
                REG_EXPONENT: exponent_next = pwdata;
                default:      modulus_next  = modulus_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_MODULUS:  prdata = modulus_reg;
            REG_EXPONENT: prdata = exponent_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else
        begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    assign cfg.modulus  = modulus_reg;
    assign cfg.exponent = exponent_reg;

endmodule

### src/bme_modmul.sv
module bme_modmul #(
    parameter int MW = bme_pkg::MODULUS_WIDTH_DEFAULT,
    parameter int BW = bme_pkg::MODULUS_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] a,
    input  logic [BW-1:0] b,
    input  logic [MW-1:0] m,
    output logic          done,
    output logic [MW-1:0] product
);
    import bme_pkg::*;

    localparam int CW = $clog2(BW);

    typedef enum logic [2:0] {
        MM_IDLE = 3'b001,
        MM_DBL  = 3'b010,
        MM_ADD  = 3'b100
    } mm_state_t;

    mm_state_t     state_reg, state_next;
    logic [MW-1:0] r_reg, r_next;
    logic [MW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic [MW-1:0] add_y;
    logic [MW:0]   sum;
    logic [MW:0]   mod_ext;
    logic [MW:0]   red;

    // shared add and reduce; a zero modulus stands for 2^MW
    assign mod_ext = {(m == '0), m};
    assign add_y   = (state_reg == MM_DBL) ? r_reg : (b_reg[BW-1] ? a_reg : '0);
    assign sum     = {1'b0, r_reg} + {1'b0, add_y};
    assign red     = (sum >= mod_ext) ? (sum - mod_ext) : sum;

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (start)
                begin
                    r_next     = '0;
                    a_next     = a;
                    b_next     = b;
                    cnt_next   = CW'(BW - 1);
                    state_next = MM_DBL;
                end
            end
            MM_DBL:
            begin
                r_next     = red[MW-1:0];
                state_next = MM_ADD;
            end
            MM_ADD:
            begin
                r_next = red[MW-1:0];
                b_next = b_reg << 1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = MM_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = MM_DBL;
                end
            end
            default: state_next = MM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

### src/byte_modular_exponentiation.sv
// Byte modular exponentiation.
// Input channel: an item (key_value) is taken on a clock edge with start high
// and busy low. Key values 0xA, 0xB and 0xF are dropped and give no result.
// Other keys get 48 added and the block computes (key+48)^e mod n.
// Result channel: cipher_value is shown for one cycle with done high. The
// receiver cannot stall; each result must be taken in that cycle.
// Config: APB port, rsa_modulus at 0x0, public_exponent at 0x4, zero wait
// states. Write only while busy is low.
// Datapath: one shared modular multiplier (double-then-add per multiplier bit,
// one add and compare per cycle) steps through B = max(MODULUS_WIDTH,9) bits.
// An item costs one base reduction plus, per exponent bit up to the top set
// bit, a pass through the STEP and NEXT states, a multiply where the bit is set
// and a square below the top bit. The result comes with done in the same cycle
// that busy falls, and the next item can be taken in that same cycle.
// Zero exponent gives 1 in the cycle after the item, with no busy period.
// Reset: modulus 1, exponent 65537, block idle, no result pending.
module byte_modular_exponentiation #(
    parameter int MODULUS_WIDTH  = bme_pkg::MODULUS_WIDTH_DEFAULT,
    parameter int EXPONENT_WIDTH = bme_pkg::EXPONENT_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bme_pkg::KEY_WIDTH-1:0]    key_value,
    output logic                             done,
    output logic [bme_pkg::CIPHER_WIDTH-1:0] cipher_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bme_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [bme_pkg::CFG_WIDTH-1:0]    pwdata,
    output logic [bme_pkg::CFG_WIDTH-1:0]    prdata,
    output logic                             pready
);
    import bme_pkg::*;

    localparam int MW = MODULUS_WIDTH;
    localparam int EW = EXPONENT_WIDTH;
    localparam int BW = (MW > BASE_WIDTH) ? MW : BASE_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RED  = 6'b000010,
        ST_STEP = 6'b000100,
        ST_MACC = 6'b001000,
        ST_NEXT = 6'b010000,
        ST_SQR  = 6'b100000
    } state_t;

    cfg_t                    cfg;
    state_t                  state_reg, state_next;
    logic [EW-1:0]           e_reg, e_next;
    logic [MW-1:0]           acc_reg, acc_next;
    logic [MW-1:0]           base_reg, base_next;
    logic [CIPHER_WIDTH-1:0] cipher_reg, cipher_next;
    logic                    done_reg, done_next;

    logic [MW-1:0]           m_val;
    logic [EW-1:0]           e_val;
    logic [MW-1:0]           one_mod;
    logic [BASE_WIDTH-1:0]   base_raw;
    logic                    rejected;
    logic [EW-1:0]           e_shift;

    logic                    mm_start;
    logic [MW-1:0]           mm_a;
    logic [BW-1:0]           mm_b;
    logic                    mm_done;
    logic [MW-1:0]           mm_product;

    bme_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bme_modmul #(
        .MW (MW),
        .BW (BW)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .m       (m_val),
        .done    (mm_done),
        .product (mm_product)
    );

    assign m_val    = MW'(cfg.modulus);
    assign e_val    = EW'(cfg.exponent);
    // 1 reduced by the modulus: only a unit modulus turns it into 0
    assign one_mod  = (m_val == MW'(1)) ? '0 : MW'(1);
    assign base_raw = {1'b0, key_value} + ASCII_OFFSET;
    assign rejected = (key_value == REJECT_A) || (key_value == REJECT_B) ||
                      (key_value == REJECT_F);
    assign e_shift  = e_reg >> 1;

    always_comb
    begin
        state_next  = state_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        cipher_next = cipher_reg;
        done_next   = 1'b0;
        mm_start    = 1'b0;
        mm_a        = acc_reg;
        mm_b        = BW'(base_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !rejected)
                begin
                    if (e_val == '0)
                    begin
                        done_next   = 1'b1;
                        cipher_next = CIPHER_WIDTH'(1);
                    end
                    else
                    begin
                        // reduce the base by multiplying it with 1 mod n
                        e_next     = e_val;
                        mm_start   = 1'b1;
                        mm_a       = one_mod;
                        mm_b       = BW'(base_raw);
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    acc_next   = one_mod;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg[0])
                begin
                    mm_start   = 1'b1;
                    state_next = ST_MACC;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_MACC:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_product;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                e_next = e_shift;
                if (e_shift == '0)
                begin
                    done_next   = 1'b1;
                    cipher_next = CIPHER_WIDTH'(acc_reg);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = base_reg;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    state_next = ST_STEP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        cipher_reg <= cipher_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign cipher_value = cipher_reg;

endmodule
